FILE: hdl/gcdpf_pkg.sv
// gcdpf_pkg: shared widths and control/status types for the gcd unit
// used by gcdpf_serial_sub and gcd_by_prime_factors_unit; no dependencies
package gcdpf_pkg;

	localparam int VALUE_WIDTH = 31;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

	// control from the sequencer to the serial subtractor
	typedef struct packed {
		logic step;   // consume one bit pair this cycle
		logic first;  // this is the lsb of a new pass
	} sub_ctrl_t;

	// result flags of a finished pass
	typedef struct packed {
		logic borrow;   // a - b went negative, so a < b
		logic nonzero;  // a - b had at least one set bit
	} sub_status_t;

endpackage

FILE: hdl/gcdpf_serial_sub.sv
// gcdpf_serial_sub: lsb-first bit-serial subtractor forming a-b and b-a at once
// depends on gcdpf_pkg
module gcdpf_serial_sub
	import gcdpf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  sub_ctrl_t              ctrl,
	input  logic                   a_bit,
	input  logic                   b_bit,
	output logic [VALUE_WIDTH-1:0] diff_ab,
	output logic [VALUE_WIDTH-1:0] diff_ba,
	output sub_status_t            status
);

	logic                   br_ab_q;
	logic                   br_ba_q;
	logic                   nz_q;
	logic [VALUE_WIDTH-1:0] diff_ab_q;
	logic [VALUE_WIDTH-1:0] diff_ba_q;

	logic br_ab_in;
	logic br_ba_in;
	logic d_ab;
	logic d_ba;
	logic br_ab_nxt;
	logic br_ba_nxt;

	always_comb begin
		br_ab_in  = ctrl.first ? 1'b0 : br_ab_q;
		br_ba_in  = ctrl.first ? 1'b0 : br_ba_q;
		d_ab      = a_bit ^ b_bit ^ br_ab_in;
		d_ba      = a_bit ^ b_bit ^ br_ba_in;
		br_ab_nxt = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & br_ab_in);
		br_ba_nxt = (~b_bit & a_bit) | (~(a_bit ^ b_bit) & br_ba_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_ab_q <= 1'b0;
			br_ba_q <= 1'b0;
			nz_q    <= 1'b0;
		end else if (ctrl.step) begin
			br_ab_q <= br_ab_nxt;
			br_ba_q <= br_ba_nxt;
			nz_q    <= (ctrl.first ? 1'b0 : nz_q) | d_ab;
		end
	end

	// differences fill from the top, so after a full pass bit 0 holds the lsb
	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			diff_ab_q <= {d_ab, diff_ab_q[VALUE_WIDTH-1:1]};
			diff_ba_q <= {d_ba, diff_ba_q[VALUE_WIDTH-1:1]};
		end
	end

	assign diff_ab        = diff_ab_q;
	assign diff_ba        = diff_ba_q;
	assign status.borrow  = br_ab_q;
	assign status.nonzero = nz_q;

endmodule

FILE: hdl/gcd_by_prime_factors_unit.sv
// gcd_by_prime_factors_unit: top level of the greatest common divisor unit
// depends on gcdpf_pkg and gcdpf_serial_sub
//
// Computes the greatest common divisor of two unsigned operands with the
// binary (shift and subtract) method; when either operand is 0 or 1 the
// result is 1. One operand pair is worked at a time: in_stall is high from
// the accepted beat until the result is moved into the output register, and
// that register lets the next pair start while a result still waits on
// out_stall. Each subtraction is one bit-serial pass through gcdpf_serial_sub
// followed by a pick state and a parity check in ST_ODDS, there are at most
// about 2*W such passes for W-bit operands, and each stripped or restored
// factor of two costs one shift. No configuration and no state kept between
// pairs.
module gcd_by_prime_factors_unit
	import gcdpf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] first_value,
	input  logic [VALUE_WIDTH-1:0] second_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [VALUE_WIDTH-1:0] divisor
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TWOS,   // strip common factors of two, counting them
		ST_ODDS,   // make both operands odd
		ST_SUB,    // bit-serial subtraction pass
		ST_PICK,   // keep the difference or finish
		ST_SCALE,  // restore the common factors of two
		ST_DONE    // hand the result to the output register
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] a_q;
	logic [VALUE_WIDTH-1:0] b_q;
	logic [CNT_W-1:0]       twos_q;
	logic [CNT_W-1:0]       bit_cnt_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] divisor_q;

	sub_ctrl_t              sub_ctrl;
	sub_status_t            sub_status;
	logic [VALUE_WIDTH-1:0] diff_ab;
	logic [VALUE_WIDTH-1:0] diff_ba;
	logic                   in_small;

	// an operand below 2 has all bits above bit 0 clear
	assign in_small = (first_value[VALUE_WIDTH-1:1] == '0) ||
	                  (second_value[VALUE_WIDTH-1:1] == '0);

	assign sub_ctrl.step  = (state_q == ST_SUB);
	assign sub_ctrl.first = (state_q == ST_SUB) && (bit_cnt_q == '0);

	gcdpf_serial_sub u_sub (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (sub_ctrl),
		.a_bit   (a_q[0]),
		.b_bit   (b_q[0]),
		.diff_ab (diff_ab),
		.diff_ba (diff_ba),
		.status  (sub_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			twos_q      <= '0;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			a_q         <= '0;
			b_q         <= '0;
			divisor_q   <= '0;
		end else begin
			// result beat taken downstream and no new result loaded behind it
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						b_q    <= second_value;
						twos_q <= '0;
						if (in_small) begin
							a_q     <= {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
							state_q <= ST_DONE;
						end else begin
							a_q     <= first_value;
							state_q <= ST_TWOS;
						end
					end
				end
				ST_TWOS: begin
					if (!a_q[0] && !b_q[0]) begin
						a_q    <= {1'b0, a_q[VALUE_WIDTH-1:1]};
						b_q    <= {1'b0, b_q[VALUE_WIDTH-1:1]};
						twos_q <= twos_q + 1'b1;
					end else begin
						state_q <= ST_ODDS;
					end
				end
				ST_ODDS: begin
					if (a_q[0] && b_q[0]) begin
						bit_cnt_q <= '0;
						state_q   <= ST_SUB;
					end else begin
						if (!a_q[0]) begin
							a_q <= {1'b0, a_q[VALUE_WIDTH-1:1]};
						end
						if (!b_q[0]) begin
							b_q <= {1'b0, b_q[VALUE_WIDTH-1:1]};
						end
					end
				end
				ST_SUB: begin
					// rotate so both operands are back in place after the pass
					a_q       <= {a_q[0], a_q[VALUE_WIDTH-1:1]};
					b_q       <= {b_q[0], b_q[VALUE_WIDTH-1:1]};
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == CNT_W'(VALUE_WIDTH - 1)) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (!sub_status.nonzero) begin
						// operands equal: a holds the odd part of the result
						state_q <= ST_SCALE;
					end else if (!sub_status.borrow) begin
						a_q     <= diff_ab;
						state_q <= ST_ODDS;
					end else begin
						b_q     <= diff_ba;
						state_q <= ST_ODDS;
					end
				end
				ST_SCALE: begin
					if (twos_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						a_q    <= {a_q[VALUE_WIDTH-2:0], 1'b0};
						twos_q <= twos_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						divisor_q   <= a_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign divisor   = divisor_q;

endmodule
